FILE: rtl/pva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic voice allocator package
// Shared constants, code types and the control/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NUM_VOICES = 16;
  localparam int IDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;
  localparam logic [7:0] NO_NOTE         = 8'd128;

  typedef enum logic [2:0] {
    OP_NOTE_ON    = 3'd0,
    OP_NOTE_OFF   = 3'd1,
    OP_SUSTAIN    = 3'd2,
    OP_ALL_NOTES  = 3'd3,
    OP_ALL_SOUND  = 3'd4,
    OP_VOICE_DONE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_STEAL   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_FREE      = 2'd0,
    MODE_PLAYING   = 2'd1,
    MODE_RELEASING = 2'd2
  } mode_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic sweep_advance;
    logic sweep_emit;
    logic pick_emit;
  } ctl_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic is_note_on;
    logic mask_hit;
    logic mask_empty;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/pva_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel carrying one note, pedal or voice event.
// ----------------------------------------------------------------------------
interface pva_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] note;
  logic [6:0] velocity_or_value;
  logic [3:0] voice_id;

  modport source (output valid, opcode, note, velocity_or_value, voice_id, input ready);
  modport sink   (input valid, opcode, note, velocity_or_value, voice_id, output ready);
endinterface

FILE: rtl/pva_command_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice command channel
// Valid/ready channel carrying one command addressed to a voice engine.
// ----------------------------------------------------------------------------
interface pva_command_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] target_voice;
  logic [6:0] note_out;
  logic [6:0] velocity_out;
  logic [7:0] glide_from;
  logic       last;

  modport source (output valid, command, target_voice, note_out, velocity_out, glide_from,
                  last, input ready);
  modport sink   (input valid, command, target_voice, note_out, velocity_out, glide_from,
                  last, output ready);
endinterface

FILE: rtl/pva_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice table, event register, hit mask, age scan trackers and the output
// register for voice commands.
// ----------------------------------------------------------------------------
module pva_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pva_pkg::ctl_cmd_t   ctl,
  output pva_pkg::dp_status_t st,
  input  logic [2:0]          opcode,
  input  logic [6:0]          note,
  input  logic [6:0]          velocity_or_value,
  input  logic [3:0]          voice_id,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          command,
  output logic [3:0]          target_voice,
  output logic [6:0]          note_out,
  output logic [6:0]          velocity_out,
  output logic [7:0]          glide_from,
  output logic                last
);
  import pva_pkg::*;

  // Voice table
  mode_t                 mode      [NUM_VOICES];
  mode_t                 mode_next [NUM_VOICES];
  logic [6:0]            pitch     [NUM_VOICES];
  logic [31:0]           age       [NUM_VOICES];
  logic [NUM_VOICES-1:0] hold, hold_next;
  logic                  pedal, pedal_next;
  logic [31:0]           start_counter;
  logic [7:0]            prev_note;

  // Event and sweep state
  logic [6:0]            ev_note, ev_vel;
  logic [NUM_VOICES-1:0] mask, mask_next, mask_rest;
  cmd_t                  sweep_cmd, sweep_cmd_next;
  logic [IDX_W-1:0]      idx;

  // Note-on scan trackers
  logic                  free_found, rel_found;
  logic [IDX_W-1:0]      free_idx, rel_idx, best_idx, pick_idx;
  logic [31:0]           rel_age, best_age, cur_age, new_age;
  cmd_t                  pick_cmd;

  logic [NUM_VOICES-1:0] playing_v, busy_v, pitch_hit;
  logic                  is_note_off, pedal_req, vid_ok;
  logic [IDX_W-1:0]      vid_idx;
  logic                  out_free;

  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      playing_v[i] = (mode[i] == MODE_PLAYING);
      busy_v[i]    = (mode[i] != MODE_FREE);
      pitch_hit[i] = playing_v[i] && (pitch[i] == note);
    end
  end

  assign is_note_off = (opcode == OP_NOTE_OFF) ||
                       ((opcode == OP_NOTE_ON) && (velocity_or_value == 7'd0));
  assign pedal_req   = (velocity_or_value >= PEDAL_THRESHOLD);
  assign vid_ok      = (32'(voice_id) < 32'(NUM_VOICES));
  assign vid_idx     = IDX_W'(voice_id);
  assign cur_age     = age[idx];
  assign new_age     = start_counter + 32'd1;
  assign out_free    = !out_valid || out_ready;

  assign pick_idx = free_found ? free_idx : (rel_found ? rel_idx : best_idx);
  assign pick_cmd = free_found ? CMD_START : CMD_STEAL;

  always_comb begin
    mask_rest      = mask;
    mask_rest[idx] = 1'b0;
  end

  always_comb begin
    mode_next      = mode;
    hold_next      = hold;
    pedal_next     = pedal;
    mask_next      = mask;
    sweep_cmd_next = sweep_cmd;
    if (ctl.accept) begin
      mask_next      = '0;
      sweep_cmd_next = CMD_RELEASE;
      unique case (opcode)
        OP_NOTE_ON, OP_NOTE_OFF: begin
          if (is_note_off) begin
            // With the pedal down the note-off is only remembered.
            if (pedal) begin
              hold_next = hold | pitch_hit;
            end else begin
              mask_next = pitch_hit;
            end
          end
        end
        OP_SUSTAIN: begin
          if (!pedal_req && pedal) begin
            mask_next = hold & playing_v;
            hold_next = '0;
          end
          pedal_next = pedal_req;
        end
        OP_ALL_NOTES: begin
          mask_next  = playing_v;
          hold_next  = '0;
          pedal_next = 1'b0;
        end
        OP_ALL_SOUND: begin
          mask_next      = busy_v;
          sweep_cmd_next = CMD_STOP;
          hold_next      = '0;
          pedal_next     = 1'b0;
        end
        OP_VOICE_DONE: begin
          if (vid_ok) begin
            mode_next[vid_idx] = MODE_FREE;
            hold_next[vid_idx] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (ctl.sweep_emit) begin
      mode_next[idx] = (sweep_cmd == CMD_STOP) ? MODE_FREE : MODE_RELEASING;
      mask_next[idx] = 1'b0;
    end
    if (ctl.pick_emit) begin
      mode_next[pick_idx] = MODE_PLAYING;
      hold_next[pick_idx] = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        mode[i] <= MODE_FREE;
      end
      hold          <= '0;
      pedal         <= 1'b0;
      mask          <= '0;
      start_counter <= '0;
      prev_note     <= NO_NOTE;
      out_valid     <= 1'b0;
      free_found    <= 1'b0;
      rel_found     <= 1'b0;
    end else begin
      mode  <= mode_next;
      hold  <= hold_next;
      pedal <= pedal_next;
      mask  <= mask_next;
      if (ctl.pick_emit) begin
        start_counter <= new_age;
        prev_note     <= {1'b0, ev_note};
      end
      if (ctl.sweep_emit || ctl.pick_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.accept) begin
        free_found <= 1'b0;
        rel_found  <= 1'b0;
      end else if (ctl.scan_step) begin
        if ((mode[idx] == MODE_FREE) && !free_found) begin
          free_found <= 1'b1;
        end
        if ((mode[idx] == MODE_RELEASING) && (!rel_found || (cur_age < rel_age))) begin
          rel_found <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sweep_cmd <= sweep_cmd_next;
    if (ctl.accept) begin
      ev_note <= note;
      ev_vel  <= velocity_or_value;
      idx     <= '0;
    end else if (ctl.scan_step || ctl.sweep_advance) begin
      idx <= idx + IDX_W'(1);
    end
    if (ctl.scan_step) begin
      if ((mode[idx] == MODE_FREE) && !free_found) begin
        free_idx <= idx;
      end
      // The first voice seeds the oldest search; ties keep the lower index.
      if ((idx == '0) || (cur_age < best_age)) begin
        best_age <= cur_age;
        best_idx <= idx;
      end
      if ((mode[idx] == MODE_RELEASING) && (!rel_found || (cur_age < rel_age))) begin
        rel_age <= cur_age;
        rel_idx <= idx;
      end
    end
    if (ctl.pick_emit) begin
      pitch[pick_idx] <= ev_note;
      age[pick_idx]   <= new_age;
      command         <= pick_cmd;
      target_voice    <= 4'(pick_idx);
      note_out        <= ev_note;
      velocity_out    <= ev_vel;
      glide_from      <= prev_note;
      last            <= 1'b1;
    end else if (ctl.sweep_emit) begin
      command      <= sweep_cmd;
      target_voice <= 4'(idx);
      note_out     <= '0;
      velocity_out <= '0;
      glide_from   <= '0;
      last         <= (mask_rest == '0);
    end
  end

  assign st.is_note_on = (opcode == OP_NOTE_ON) && (velocity_or_value != 7'd0);
  assign st.mask_hit   = mask[idx];
  assign st.mask_empty = (mask == '0);
  assign st.scan_last  = (idx == IDX_W'(NUM_VOICES - 1));
  assign st.out_free   = out_free;

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.sweep_emit || ctl.pick_emit) |-> out_free)
    else $error("output register loaded while holding an untaken transaction");

  a_sweep_on_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep_emit |-> mask[idx])
    else $error("sweep emitted a command for a voice outside the hit mask");

  a_release_leaves_playing: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep_emit |=> (mode[$past(idx)] != MODE_PLAYING))
    else $error("voice still playing after a release or stop command");

  a_pick_plays: assert property (@(posedge clk) disable iff (rst)
    ctl.pick_emit |=> (mode[$past(pick_idx)] == MODE_PLAYING))
    else $error("allocated voice is not playing after start or steal");

endmodule

FILE: rtl/pva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator sequencer
// Accepts events, steps the voice scan for note-on and the command sweep for
// the other events, and throttles on the output register.
// ----------------------------------------------------------------------------
module pva_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pva_pkg::dp_status_t st,
  output pva_pkg::ctl_cmd_t   ctl
);
  import pva_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_PICK  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next        = state;
    ctl               = '0;
    in_ready          = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
        if (in_valid) begin
          state_next = st.is_note_on ? S_SCAN : S_SWEEP;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        ctl.pick_emit = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (st.mask_empty) begin
          state_next = S_IDLE;
        end else begin
          // A hit waits for room in the output register; a miss moves on.
          ctl.sweep_emit    = st.mask_hit && st.out_free;
          ctl.sweep_advance = !st.mask_hit || st.out_free;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_single_action: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |-> !(ctl.scan_step || ctl.sweep_emit || ctl.pick_emit))
    else $error("event accepted while the datapath is still working");

endmodule

FILE: rtl/poly_voice_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Turns note, pedal and voice-finished events into start, steal, release and
// hard-stop commands for a bank of voices, stealing the oldest releasing voice, else the oldest voice.
//
// note_event carries one event per transaction; voice_command carries one
// command per transaction, with last set on the final command of an event.
// Events that address no voice produce no command.
// A note-on scans all voices, one per cycle, then issues its single command
// when the output register has room. Release and stop sweeps visit one
// voice per cycle, except that a hit waits for room in the output register,
// and emit at most one command per cycle. One event is in work at a time;
// the next is accepted once the last command sits in the output
// register. A stalled receiver holds the output register and the sweep
// waits on it. Reset frees all voices, lifts the pedal, clears the start
// counter and marks the previous note as none.
// ----------------------------------------------------------------------------
module poly_voice_allocator (
  input  logic                 clk,
  input  logic                 rst,
  pva_event_if.sink            note_event,
  pva_command_if.source        voice_command
);
  import pva_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t st;
  logic       in_ready;

  assign note_event.ready = in_ready;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (note_event.valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  pva_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .st                (st),
    .opcode            (note_event.opcode),
    .note              (note_event.note),
    .velocity_or_value (note_event.velocity_or_value),
    .voice_id          (note_event.voice_id),
    .out_ready         (voice_command.ready),
    .out_valid         (voice_command.valid),
    .command           (voice_command.command),
    .target_voice      (voice_command.target_voice),
    .note_out          (voice_command.note_out),
    .velocity_out      (voice_command.velocity_out),
    .glide_from        (voice_command.glide_from),
    .last              (voice_command.last)
  );

endmodule

FILE: test/pva_voice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator scoreboard
// Watches the event and command channels, keeps its own copy of the voice
// table, pedal, start stamp and previous note, and compares every command
// transaction against the oldest predicted command.
// ----------------------------------------------------------------------------
module pva_voice_checker
  import pva_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  pva_event_if   evt,
  pva_command_if cmd,
  output int     errors,
  output int     outstanding
);

  typedef struct packed {
    cmd_t             command;
    logic [IDX_W-1:0] target;
    logic [6:0]       pitch;
    logic [6:0]       velocity;
    logic [7:0]       glide;
    logic             last;
  } voice_cmd_t;

  mode_t       vmode    [NUM_VOICES];
  logic [6:0]  vpitch   [NUM_VOICES];
  logic [31:0] vage     [NUM_VOICES];
  logic        held     [NUM_VOICES];
  logic        pedal;
  logic [31:0] stamp;
  logic [7:0]  prev_note;

  voice_cmd_t event_cmds[$];
  voice_cmd_t expected_cmds[$];

  function automatic voice_cmd_t make_cmd(input cmd_t kind, input int voice,
                                          input logic [6:0] pitch,
                                          input logic [6:0] velocity,
                                          input logic [7:0] glide);
    voice_cmd_t c;
    c.command  = kind;
    c.target   = IDX_W'(voice);
    c.pitch    = pitch;
    c.velocity = velocity;
    c.glide    = glide;
    c.last     = 1'b0;
    return c;
  endfunction

  task automatic reset_voices();
    for (int i = 0; i < NUM_VOICES; i++) begin
      vmode[i]  = MODE_FREE;
      vpitch[i] = '0;
      vage[i]   = '0;
      held[i]   = 1'b0;
    end
    pedal     = 1'b0;
    stamp     = '0;
    prev_note = NO_NOTE;
  endtask

  task automatic note_release(input logic [6:0] nt);
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (vmode[i] == MODE_PLAYING && vpitch[i] == nt) begin
        // A held pedal only marks the voice; the release comes when it lifts.
        if (pedal) begin
          held[i] = 1'b1;
        end else begin
          vmode[i] = MODE_RELEASING;
          event_cmds.push_back(make_cmd(CMD_RELEASE, i, '0, '0, '0));
        end
      end
    end
  endtask

  task automatic release_sweep(input bit marked_only);
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (!marked_only || held[i]) begin
        if (vmode[i] == MODE_PLAYING) begin
          vmode[i] = MODE_RELEASING;
          event_cmds.push_back(make_cmd(CMD_RELEASE, i, '0, '0, '0));
        end
        held[i] = 1'b0;
      end
    end
  endtask

  task automatic allocate_voice(input logic [6:0] nt, input logic [6:0] vel);
    int   pick;
    int   oldest;
    int   oldest_rel;
    cmd_t kind;
    pick       = -1;
    oldest     = -1;
    oldest_rel = -1;
    kind       = CMD_START;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (pick < 0 && vmode[i] == MODE_FREE) pick = i;
    end
    if (pick < 0) begin
      // No free voice: the oldest releasing voice goes first, else the oldest
      // voice overall. Strict compares keep the lowest index on a tie.
      kind = CMD_STEAL;
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (oldest < 0 || vage[i] < vage[oldest]) oldest = i;
        if (vmode[i] == MODE_RELEASING && (oldest_rel < 0 || vage[i] < vage[oldest_rel]))
          oldest_rel = i;
      end
      pick = (oldest_rel >= 0) ? oldest_rel : oldest;
    end
    stamp        = stamp + 32'd1;
    vmode[pick]  = MODE_PLAYING;
    vpitch[pick] = nt;
    vage[pick]   = stamp;
    held[pick]   = 1'b0;
    event_cmds.push_back(make_cmd(kind, pick, nt, vel, prev_note));
    prev_note = {1'b0, nt};
  endtask

  task automatic predict_event(input logic [2:0] op, input logic [6:0] nt,
                               input logic [6:0] val, input logic [3:0] vid);
    event_cmds.delete();
    case (op)
      OP_NOTE_ON: begin
        if (val == 7'd0) note_release(nt);
        else allocate_voice(nt, val);
      end
      OP_NOTE_OFF: begin
        note_release(nt);
      end
      OP_SUSTAIN: begin
        if (val < PEDAL_THRESHOLD && pedal) release_sweep(1'b1);
        pedal = (val >= PEDAL_THRESHOLD);
      end
      OP_ALL_NOTES: begin
        release_sweep(1'b0);
        pedal = 1'b0;
      end
      OP_ALL_SOUND: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (vmode[i] != MODE_FREE) begin
            vmode[i] = MODE_FREE;
            event_cmds.push_back(make_cmd(CMD_STOP, i, '0, '0, '0));
          end
          held[i] = 1'b0;
        end
        pedal = 1'b0;
      end
      OP_VOICE_DONE: begin
        if (int'(vid) < NUM_VOICES) begin
          vmode[vid] = MODE_FREE;
          held[vid]  = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (event_cmds.size() > 0) event_cmds[event_cmds.size() - 1].last = 1'b1;
    foreach (event_cmds[i]) expected_cmds.push_back(event_cmds[i]);
  endtask

  always @(posedge clk) begin : watch
    voice_cmd_t want;
    voice_cmd_t seen;
    if (rst) begin
      reset_voices();
      expected_cmds.delete();
    end else begin
      // A command taken at this edge always belongs to an earlier event, so
      // it is checked before the event of this edge is predicted.
      if (cmd.valid && cmd.ready) begin
        seen.command  = cmd_t'(cmd.command);
        seen.target   = cmd.target_voice;
        seen.pitch    = cmd.note_out;
        seen.velocity = cmd.velocity_out;
        seen.glide    = cmd.glide_from;
        seen.last     = cmd.last;
        if (expected_cmds.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected command transaction, expected none, actual cmd %0d",
                   $time, seen.command,
                   " voice %0d note %0d vel %0d glide %0d last %0d",
                   seen.target, seen.pitch, seen.velocity, seen.glide, seen.last);
        end else begin
          want = expected_cmds.pop_front();
          if (seen !== want) begin
            errors = errors + 1;
            $display("%0t: command mismatch, expected cmd %0d voice %0d note %0d",
                     $time, want.command, want.target, want.pitch,
                     " vel %0d glide %0d last %0d", want.velocity, want.glide, want.last,
                     ", actual cmd %0d voice %0d note %0d", seen.command, seen.target,
                     seen.pitch, " vel %0d glide %0d last %0d", seen.velocity,
                     seen.glide, seen.last);
          end
        end
      end
      if (evt.valid && evt.ready)
        predict_event(evt.opcode, evt.note, evt.velocity_or_value, evt.voice_id);
    end
    outstanding <= expected_cmds.size();
  end

endmodule

FILE: test/poly_voice_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives directed and random note, pedal and voice-finished events into the
// allocator under changing source and sink stall patterns, and lets the
// scoreboard check every voice command.
// ----------------------------------------------------------------------------
module poly_voice_allocator_tb;
  import pva_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 12;
  localparam int PHASE_ITEMS  = 143;
  localparam int LIMIT_CYCLES = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   src_idle = 30;
  int   snk_idle = 75;
  logic [6:0] recent_notes [8];

  pva_event_if   ev_ch ();
  pva_command_if cmd_ch ();

  poly_voice_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .note_event    (ev_ch),
    .voice_command (cmd_ch)
  );

  pva_voice_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .evt         (ev_ch),
    .cmd         (cmd_ch),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cmd_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_event(input logic [2:0] op, input logic [6:0] nt,
                            input logic [6:0] val, input logic [3:0] vid);
    while ($urandom_range(99) < src_idle) begin
      ev_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ev_ch.valid             <= 1'b1;
    ev_ch.opcode            <= op;
    ev_ch.note              <= nt;
    ev_ch.velocity_or_value <= val;
    ev_ch.voice_id          <= vid;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
  endtask

  // The extra edge lets the scoreboard count an event taken at this edge.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_event(output bit counted);
    int         r;
    logic [2:0] op;
    logic [6:0] nt;
    logic [6:0] val;
    logic [3:0] vid;
    r       = $urandom_range(99);
    counted = 1'b1;
    // Most note numbers come from a short list so that note-offs find voices.
    nt  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : recent_notes[$urandom_range(7)];
    val = 7'($urandom_range(127));
    vid = 4'($urandom_range(15));
    if (r < 45) begin
      op  = OP_NOTE_ON;
      val = ($urandom_range(19) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      if (val != 7'd0) recent_notes[$urandom_range(7)] = nt;
    end else if (r < 65) begin
      op = OP_NOTE_OFF;
    end else if (r < 76) begin
      op = OP_SUSTAIN;
    end else if (r < 89) begin
      op = OP_VOICE_DONE;
    end else if (r < 93) begin
      op = OP_ALL_NOTES;
    end else if (r < 96) begin
      op = OP_ALL_SOUND;
    end else begin
      op      = 3'($urandom_range(6, 7));
      counted = 1'b0;
    end
    send_event(op, nt, val, vid);
  endtask

  initial begin
    int sent;
    bit counted;
    ev_ch.valid             = 1'b0;
    ev_ch.opcode            = '0;
    ev_ch.note              = '0;
    ev_ch.velocity_or_value = '0;
    ev_ch.voice_id          = '0;
    cmd_ch.ready            = 1'b0;
    foreach (recent_notes[i]) recent_notes[i] = 7'(i * 15 + 4);
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_event(OP_NOTE_ON, 7'd60, 7'd100, 4'd0);
    send_event(OP_NOTE_ON, 7'd0, 7'd127, 4'd15);
    send_event(OP_NOTE_ON, 7'd127, 7'd1, 4'd0);
    // Velocity zero acts as a note-off.
    send_event(OP_NOTE_ON, 7'd60, 7'd0, 4'd0);
    send_event(OP_NOTE_OFF, 7'd127, 7'd0, 4'd0);
    send_event(OP_NOTE_OFF, 7'd5, 7'd0, 4'd0);
    send_event(OP_SUSTAIN, 7'd0, 7'd64, 4'd0);
    send_event(OP_SUSTAIN, 7'd0, 7'd127, 4'd0);
    send_event(OP_NOTE_OFF, 7'd0, 7'd0, 4'd0);
    send_event(OP_NOTE_ON, 7'd0, 7'd90, 4'd0);
    send_event(OP_SUSTAIN, 7'd0, 7'd63, 4'd0);
    send_event(OP_SUSTAIN, 7'd0, 7'd0, 4'd0);
    send_event(OP_VOICE_DONE, 7'd0, 7'd0, 4'd0);
    send_event(OP_VOICE_DONE, 7'd127, 7'd127, 4'd15);
    send_event(OP_SUSTAIN, 7'd0, 7'd100, 4'd0);
    send_event(OP_NOTE_ON, 7'd33, 7'd50, 4'd0);
    send_event(OP_ALL_NOTES, 7'd0, 7'd0, 4'd0);
    send_event(OP_NOTE_OFF, 7'd33, 7'd0, 4'd0);
    send_event(OP_ALL_SOUND, 7'd0, 7'd0, 4'd0);
    send_event(OP_ALL_SOUND, 7'd0, 7'd0, 4'd0);
    send_event(3'd6, 7'd127, 7'd127, 4'd15);
    send_event(3'd7, 7'd127, 7'd127, 4'd15);
    ev_ch.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
      snk_idle = (phase == 0) ? 75 : (phase == 1) ? 30 : 0;
      sent     = 0;
      while (sent < PHASE_ITEMS) begin
        random_event(counted);
        if (counted) sent++;
      end
      // Hold the source until every pending command has come out.
      ev_ch.valid <= 1'b0;
      drain();
    end

    repeat (4 * NUM_VOICES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
